[hdl/assert_macros.svh]
// assertion helpers used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define CHK_IMP(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("check failed");

// next-cycle implication, off during reset
`define CHK_NXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("check failed");

// next-cycle implication that also holds while reset is asserted
`define CHK_ALW(name, clk, pre, post) \
	name: assert property (@(posedge clk) (pre) |=> (post)) \
		else $error("check failed");

`endif

[hdl/ccg_pkg.sv]
// ----------------------------------------------------------------------------
// ccg_pkg
// Shared types, widths and constants of the cosine column gain correction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ccg_pkg;

	localparam int MAX_LINE_WIDTH = 8192;
	localparam int LAYERS = 3;

	localparam int PIX_W = 8;
	localparam int COL_W = 13;
	localparam int LAY_W = 2;
	localparam int LW_W = 14;
	localparam int REG_W = 16;
	localparam int NUM_W = 24;
	localparam int PH_W = 32;
	localparam int T_W = 17;
	localparam int V_W = 30;
	localparam int R_W = 31;
	localparam int PROD_W = 61;
	localparam int G_W = 30;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
	localparam logic [T_W-1:0] HALF_TURN = 17'd65536;
	localparam logic [T_W:0] FULL_TURN = 18'd131072;
	localparam logic [T_W-1:0] QUARTER_TURN = 17'd32768;
	localparam logic [G_W-1:0] Q28_ONE = 30'd268435456;

	typedef enum logic [2:0] {
		REG_STRENGTH,
		REG_WIDTH,
		REG_LINE_WIDTH,
		REG_LEFT_EN,
		REG_RIGHT_EN,
		REG_LAYER_EN,
		REG_LAYERS_PRESENT
	} reg_idx_t;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic bypass;
		logic pos;
		logic [NUM_W-1:0] num;
	} ctx_t;

	// cosine series coefficients, Q28
	function automatic logic [R_W-1:0] cos_coef(input logic [2:0] k);
		logic [R_W-1:0] c;
		case (k)
			3'd1: c = 31'd1324675879;
			3'd2: c = 31'd1089502240;
			3'd3: c = 31'd358431870;
			3'd4: c = 31'd63171085;
			3'd5: c = 31'd6927485;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

[hdl/ccg_phase_div.sv]
// ----------------------------------------------------------------------------
// ccg_phase_div
// Pipelined restoring divider for the cosine phase, four quotient bits a stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccg_phase_div import ccg_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire ctx_t in_ctx,
	input wire logic [PH_W-1:0] in_phase,
	input wire logic [LW_W-1:0] line_width,
	output logic out_valid,
	input wire logic out_ready,
	output ctx_t out_ctx,
	output logic [T_W-1:0] out_t
);

	localparam int STAGES = 8;
	localparam int STEPS = PH_W / STAGES;

	typedef struct packed {
		logic [LW_W-1:0] rem;
		logic [PH_W-1:0] dvd;
		logic [T_W-1:0] quo;
	} dstate_t;

	function automatic dstate_t div_steps(input dstate_t s, input logic [LW_W-1:0] lw);
		dstate_t r;
		logic [LW_W:0] trial;
		r = s;
		for (int i = 0; i < STEPS; i++) begin
			trial = {r.rem, r.dvd[PH_W-1]};
			r.dvd = {r.dvd[PH_W-2:0], 1'b0};
			if (trial >= {1'b0, lw}) begin
				r.rem = LW_W'(trial - {1'b0, lw});
				r.quo = {r.quo[T_W-2:0], 1'b1};
			end else begin
				r.rem = trial[LW_W-1:0];
				r.quo = {r.quo[T_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	logic vld_s [STAGES];
	ctx_t ctx_s [STAGES];
	dstate_t dst_s [STAGES];
	logic en [STAGES];
	dstate_t nxt [STAGES];
	dstate_t seed;

	always_comb begin
		en[STAGES-1] = !vld_s[STAGES-1] || out_ready;
		for (int k = STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	always_comb begin
		seed = '{rem: '0, dvd: in_phase, quo: '0};
		nxt[0] = div_steps(seed, line_width);
		for (int k = 1; k < STAGES; k++) begin
			nxt[k] = div_steps(dst_s[k-1], line_width);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STAGES; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			if (en[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < STAGES; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ctx_s[0] <= in_ctx;
			dst_s[0] <= nxt[0];
		end
		for (int k = 1; k < STAGES; k++) begin
			if (en[k]) begin
				ctx_s[k] <= ctx_s[k-1];
				dst_s[k] <= nxt[k];
			end
		end
	end

	assign in_ready = en[0];
	assign out_valid = vld_s[STAGES-1];
	assign out_ctx = ctx_s[STAGES-1];
	assign out_t = dst_s[STAGES-1].quo;

endmodule

`default_nettype wire

[hdl/ccg_cos.sv]
// ----------------------------------------------------------------------------
// ccg_cos
// Phase folding and pipelined Horner evaluation of the cosine in Q28.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccg_cos import ccg_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire ctx_t in_ctx,
	input wire logic [T_W-1:0] in_t,
	output logic out_valid,
	input wire logic out_ready,
	output ctx_t out_ctx,
	output logic [G_W-1:0] out_g
);

	localparam int STAGES = 6;

	typedef struct packed {
		logic [V_W-1:0] v;
		logic [PROD_W-1:0] prod;
	} cstate_t;

	logic vld_s [STAGES];
	ctx_t ctx_s [STAGES];
	cstate_t cst_s [STAGES];
	logic en [STAGES];
	cstate_t nxt [STAGES];
	ctx_t ctx0;
	logic [T_W-1:0] tf;
	logic [14:0] tq;
	logic [R_W-1:0] r;

	always_comb begin
		en[STAGES-1] = !vld_s[STAGES-1] || out_ready;
		for (int k = STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	always_comb begin
		tf = (in_t > HALF_TURN) ? T_W'(FULL_TURN - {1'b0, in_t}) : in_t;
		tq = tf[14:0];
		ctx0 = in_ctx;
		ctx0.bypass = in_ctx.bypass || (tf >= QUARTER_TURN);
		nxt[0].v = V_W'(tq) * V_W'(tq);
		nxt[0].prod = '0;
		r = '0;
		for (int k = 1; k < STAGES; k++) begin
			if (k == 1) begin
				r = cos_coef(3'd5);
			end else begin
				r = cos_coef(3'(STAGES - k)) - {2'b00, cst_s[k-1].prod[PROD_W-1:32]};
			end
			nxt[k].v = cst_s[k-1].v;
			nxt[k].prod = PROD_W'(r) * PROD_W'(cst_s[k-1].v);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STAGES; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			if (en[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < STAGES; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ctx_s[0] <= ctx0;
			cst_s[0] <= nxt[0];
		end
		for (int k = 1; k < STAGES; k++) begin
			if (en[k]) begin
				ctx_s[k] <= ctx_s[k-1];
				cst_s[k] <= nxt[k];
			end
		end
	end

	assign in_ready = en[0];
	assign out_valid = vld_s[STAGES-1];
	assign out_ctx = ctx_s[STAGES-1];
	assign out_g = Q28_ONE - {1'b0, cst_s[STAGES-1].prod[PROD_W-1:32]};

endmodule

`default_nettype wire

[hdl/cosine_column_gain_correction_core.sv]
// ----------------------------------------------------------------------------
// cosine_column_gain_correction_core
// Per-pixel cosine gain correction over the columns of an image line.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock and returns one word per clock, in order,
// while out_ready holds. The pipeline has one entry stage, eight stages of the
// phase divider (32-bit dividend by line width, four quotient bits a stage),
// six stages of the cosine polynomial (one multiply a stage), and five
// stages of gain divide or multiply, clamp and output. Each stage holds its
// word under backpressure, so bubbles close up while the output waits.
// The user must write the registers on the plain write port only while no
// word is in flight; the core itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module cosine_column_gain_correction_core import ccg_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [PIX_W-1:0] pixel_in,
	input wire logic [COL_W-1:0] column,
	input wire logic [LAY_W-1:0] layer,
	output logic out_valid,
	input wire logic out_ready,
	output logic [PIX_W-1:0] pixel_out,
	output logic corrected,
	input wire logic wr_en,
	input wire logic [2:0] wr_index,
	input wire logic [REG_W-1:0] wr_data
);

	typedef struct packed {
		logic [39:0] rem;
		logic [3:0] q;
	} qhalf_t;

	function automatic qhalf_t div_half(input logic [39:0] rem, input logic [28:0] gp,
		input logic hi);
		qhalf_t r;
		logic [39:0] dv;
		r.rem = rem;
		r.q = '0;
		for (int i = 3; i >= 0; i--) begin
			dv = 40'(gp) << (hi ? i + 4 : i);
			if (r.rem >= dv) begin
				r.rem = r.rem - dv;
				r.q[i] = 1'b1;
			end
		end
		return r;
	endfunction

	// configuration
	logic [15:0] strength_q;
	logic [15:0] width_q;
	logic [LW_W-1:0] line_width_q;
	logic left_en_q;
	logic right_en_q;
	logic [2:0] layer_en_q;
	logic [1:0] layers_present_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strength_q <= 16'd4096;
			width_q <= 16'd2731;
			line_width_q <= 14'd4096;
			left_en_q <= 1'b0;
			right_en_q <= 1'b0;
			layer_en_q <= 3'd0;
			layers_present_q <= 2'd3;
		end else if (wr_en) begin
			case (wr_index)
				REG_STRENGTH: strength_q <= wr_data;
				REG_WIDTH: width_q <= wr_data;
				REG_LINE_WIDTH: line_width_q <= wr_data[LW_W-1:0];
				REG_LEFT_EN: left_en_q <= wr_data[0];
				REG_RIGHT_EN: right_en_q <= wr_data[0];
				REG_LAYER_EN: layer_en_q <= wr_data[2:0];
				REG_LAYERS_PRESENT: layers_present_q <= wr_data[1:0];
				default: ;
			endcase
		end
	end

	// entry stage
	logic [3:0] layer_en_ext;
	logic [COL_W-1:0] half;
	logic left_side;
	logic lay_ok;
	logic lw_ok;
	logic side_on;
	logic [COL_W-1:0] col_dist;
	logic [15:0] aw;
	ctx_t ctx_in;
	logic [PH_W-1:0] phase_in;

	always_comb begin
		layer_en_ext = {1'b0, layer_en_q};
		half = line_width_q[LW_W-1:1];
		left_side = column < half;
		lay_ok = (layer < layers_present_q) && (layer < LAY_W'(LAYERS)) && layer_en_ext[layer];
		lw_ok = (line_width_q >= 14'd2) && (line_width_q <= LW_W'(MAX_LINE_WIDTH))
			&& ({1'b0, column} < line_width_q);
		side_on = left_side ? left_en_q : right_en_q;
		col_dist = left_side ? (half - column) : (column - half);
		aw = width_q[15] ? (~width_q + 16'd1) : width_q;
		phase_in = (PH_W'(col_dist) * PH_W'(aw)) << 3;
		ctx_in.pix = pixel_in;
		ctx_in.bypass = !(lay_ok && lw_ok && side_on);
		ctx_in.pos = !width_q[15] && (width_q != 16'd0);
		ctx_in.num = NUM_W'(pixel_in) * NUM_W'(strength_q);
	end

	logic vld_s1;
	ctx_t ctx_s1;
	logic [PH_W-1:0] phase_s1;
	logic en_s1;

	logic div_in_ready;
	logic div_out_valid;
	ctx_t div_ctx;
	logic [T_W-1:0] div_t;

	logic cos_in_ready;
	logic cos_out_valid;
	ctx_t cos_ctx;
	logic [G_W-1:0] cos_g;

	logic vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic en_s2, en_s3, en_s4, en_s5, en_s6;

	assign en_s6 = !vld_s6 || out_ready;
	assign en_s5 = !vld_s5 || en_s6;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || div_in_ready;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ctx_s1 <= ctx_in;
			phase_s1 <= phase_in;
		end
	end

	ccg_phase_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(vld_s1),
		.in_ready(div_in_ready),
		.in_ctx(ctx_s1),
		.in_phase(phase_s1),
		.line_width(line_width_q),
		.out_valid(div_out_valid),
		.out_ready(cos_in_ready),
		.out_ctx(div_ctx),
		.out_t(div_t)
	);

	ccg_cos u_cos (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(div_out_valid),
		.in_ready(cos_in_ready),
		.in_ctx(div_ctx),
		.in_t(div_t),
		.out_valid(cos_out_valid),
		.out_ready(en_s2),
		.out_ctx(cos_ctx),
		.out_g(cos_g)
	);

	// gain stages
	ctx_t ctx_s2, ctx_s3, ctx_s4, ctx_s5;
	logic [G_W-1:0] g_s2;
	logic [28:0] gp_s3, gp_s4;
	logic sat_s3, sat_s4, sat_s5;
	logic [52:0] prod_s3;
	logic [39:0] rem_s3, rem_s4;
	logic [3:0] qhi_s4;
	logic [PIX_W-1:0] pclamp_s4, pclamp_s5;
	logic [PIX_W-1:0] q_s5;
	logic [PIX_W-1:0] pix_s6;
	logic corr_s6;

	qhalf_t hi_d, lo_d;
	ctx_t ctx_g;

	always_comb begin
		ctx_g = ctx_s2;
		ctx_g.bypass = ctx_s2.bypass || g_s2[G_W-1] || (g_s2 == '0);
		hi_d = div_half(rem_s3, gp_s3, 1'b1);
		lo_d = div_half(rem_s4, gp_s4, 1'b0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en_s2) vld_s2 <= cos_out_valid;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			ctx_s2 <= cos_ctx;
			g_s2 <= cos_g;
		end
		if (en_s3) begin
			ctx_s3 <= ctx_g;
			gp_s3 <= g_s2[28:0];
			sat_s3 <= {ctx_s2.num, 16'd0} >= {3'd0, g_s2[28:0], 8'd0};
			prod_s3 <= 53'(ctx_s2.num) * 53'(g_s2[28:0]);
			rem_s3 <= {ctx_s2.num, 16'd0};
		end
		if (en_s4) begin
			ctx_s4 <= ctx_s3;
			gp_s4 <= gp_s3;
			sat_s4 <= sat_s3;
			rem_s4 <= hi_d.rem;
			qhi_s4 <= hi_d.q;
			pclamp_s4 <= (prod_s3[52:48] != 5'd0) ? PIX_MAX : prod_s3[47:40];
		end
		if (en_s5) begin
			ctx_s5 <= ctx_s4;
			sat_s5 <= sat_s4;
			q_s5 <= {qhi_s4, lo_d.q};
			pclamp_s5 <= pclamp_s4;
		end
		if (en_s6) begin
			corr_s6 <= !ctx_s5.bypass;
			if (ctx_s5.bypass) begin
				pix_s6 <= ctx_s5.pix;
			end else if (ctx_s5.pos) begin
				pix_s6 <= sat_s5 ? PIX_MAX : q_s5;
			end else begin
				pix_s6 <= pclamp_s5;
			end
		end
	end

	assign out_valid = vld_s6;
	assign pixel_out = pix_s6;
	assign corrected = corr_s6;

endmodule

`default_nettype wire

[hdl/ccg_checker.sv]
// ----------------------------------------------------------------------------
// ccg_checker
// Port-level checks of the correction core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ccg_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic [7:0] pixel_in,
	input wire logic [12:0] column,
	input wire logic [1:0] layer,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [7:0] pixel_out,
	input wire logic corrected,
	input wire logic wr_en
);

	logic [22:0] in_word;
	logic [8:0] out_word;

	assign in_word = {pixel_in, column, layer};
	assign out_word = {pixel_out, corrected};

	// a stalled output word holds
	`CHK_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_word))

	// a waiting input word holds
	`CHK_NXT(a_in_hold, clk, arst_n, in_valid && !in_ready, in_valid && $stable(in_word))

	// a drained output lets the whole pipe move
	`CHK_IMP(a_ready_flow, clk, arst_n, out_ready, in_ready)

	// a register write comes only with no input offered and no output valid
	`CHK_IMP(a_cfg_idle, clk, arst_n, wr_en, !in_valid && !out_valid)

	// reset empties the pipe
	`CHK_ALW(a_reset_empty, clk, !arst_n, !out_valid && in_ready)

endmodule

bind cosine_column_gain_correction_core ccg_checker u_ccg_checker (.*);

`default_nettype wire
